// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is asserted
`define PSFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define PSFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSFD_ASSERT(label, clk, rst_n, prop, msg)
`define PSFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: src/psfd_pkg.sv
// ----------------------------------------------------------------------------
// psfd_pkg
// Types and constants shared by the particle sensor frame detector.
// ----------------------------------------------------------------------------
package psfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned READING_W = 16;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;

    // Header register reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h16;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h11;
    localparam logic [BYTE_W-1:0] HEADER_THIRD_RST  = 8'h0B;

    // Window positions of the reading, counted from the oldest byte
    localparam int unsigned READING_HI_POS = 5;
    localparam int unsigned READING_LO_POS = 6;

    typedef enum logic [1:0] {
        STATUS_NO_HEADER = 2'd0,
        STATUS_BAD_SUM   = 2'd1,
        STATUS_VALID     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_HEADER_THIRD  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] third;
    } header_cfg_t;

    typedef struct packed {
        status_t              status;
        logic [READING_W-1:0] reading;
    } result_t;

endpackage

// File: src/psfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// psfd_cfg_regs
// APB register file holding the three expected header bytes.
// ----------------------------------------------------------------------------
module psfd_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [psfd_pkg::DATA_W-1:0]  pwdata,
    output logic [psfd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output psfd_pkg::header_cfg_t        hdr
);

    psfd_pkg::header_cfg_t hdr_reg;
    psfd_pkg::header_cfg_t hdr_next;
    logic                  wr_en;
    psfd_pkg::reg_idx_t    idx;
    logic [psfd_pkg::BYTE_W-1:0] wbyte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = psfd_pkg::reg_idx_t'(paddr[3:2]);
    assign wbyte  = pwdata[psfd_pkg::BYTE_W-1:0];

    // Decode write to the addressed header byte; drop unmapped addresses
    always_comb
    begin
        hdr_next = hdr_reg;
        if (wr_en)
        begin
            case (idx)
                psfd_pkg::REG_HEADER_FIRST:  hdr_next.first  = wbyte;
                psfd_pkg::REG_HEADER_SECOND: hdr_next.second = wbyte;
                psfd_pkg::REG_HEADER_THIRD:  hdr_next.third  = wbyte;
                default:                     hdr_next = hdr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg.first  <= psfd_pkg::HEADER_FIRST_RST;
            hdr_reg.second <= psfd_pkg::HEADER_SECOND_RST;
            hdr_reg.third  <= psfd_pkg::HEADER_THIRD_RST;
        end
        else
        begin
            hdr_reg <= hdr_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            psfd_pkg::REG_HEADER_FIRST:
                prdata = {{(psfd_pkg::DATA_W-psfd_pkg::BYTE_W){1'b0}}, hdr_reg.first};
            psfd_pkg::REG_HEADER_SECOND:
                prdata = {{(psfd_pkg::DATA_W-psfd_pkg::BYTE_W){1'b0}}, hdr_reg.second};
            psfd_pkg::REG_HEADER_THIRD:
                prdata = {{(psfd_pkg::DATA_W-psfd_pkg::BYTE_W){1'b0}}, hdr_reg.third};
            default:
                prdata = '0;
        endcase
    end

    assign hdr = hdr_reg;

endmodule

// File: src/psfd_window.sv
// ----------------------------------------------------------------------------
// psfd_window
// Byte shift window with a running modulo-256 sum and the frame check.
// ----------------------------------------------------------------------------
module psfd_window
#(
    parameter int unsigned FRAME_BYTES = 20
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [psfd_pkg::BYTE_W-1:0]  rx_byte,
    input  psfd_pkg::header_cfg_t        hdr,
    output psfd_pkg::result_t            result
);

    logic [psfd_pkg::BYTE_W-1:0] window_reg  [FRAME_BYTES];
    logic [psfd_pkg::BYTE_W-1:0] window_next [FRAME_BYTES];
    logic [psfd_pkg::BYTE_W-1:0] sum_reg;
    logic [psfd_pkg::BYTE_W-1:0] sum_next;
    logic                        hdr_match;

    // Shift by one byte: oldest drops out, new byte enters the young end
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[FRAME_BYTES-1] = rx_byte;
    end

    // Running window sum, wraps modulo 256
    assign sum_next = sum_reg - window_reg[0] + rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            sum_reg    <= sum_next;
        end
    end

    // Classify the window as it stands after this byte
    assign hdr_match = (window_next[0] == hdr.first)  &&
                       (window_next[1] == hdr.second) &&
                       (window_next[2] == hdr.third);

    always_comb
    begin
        result.reading = '0;
        if (!hdr_match)
        begin
            result.status = psfd_pkg::STATUS_NO_HEADER;
        end
        else if (sum_next != '0)
        begin
            result.status = psfd_pkg::STATUS_BAD_SUM;
        end
        else
        begin
            result.status  = psfd_pkg::STATUS_VALID;
            result.reading = {window_next[psfd_pkg::READING_HI_POS],
                              window_next[psfd_pkg::READING_LO_POS]};
        end
    end

endmodule

// File: src/psfd_out_skid.sv
// ----------------------------------------------------------------------------
// psfd_out_skid
// Result register with a skid stage; input stalls only while the skid slot is
// occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psfd_out_skid
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  psfd_pkg::result_t               result_in,
    output logic                            full,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      frame_status,
    output logic [psfd_pkg::READING_W-1:0]  particle_reading
);

    logic              main_valid_reg;
    logic              main_valid_next;
    psfd_pkg::result_t main_reg;
    psfd_pkg::result_t main_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    psfd_pkg::result_t skid_reg;
    psfd_pkg::result_t skid_next;
    logic              out_fire;

    assign out_fire = main_valid_reg && !out_stall;

    // Advance the output slot; park a transaction in the skid slot on stall
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_fire || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_valid_next = 1'b1;
                main_next       = result_in;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full             = skid_valid_reg;
    assign out_valid        = main_valid_reg;
    assign frame_status     = main_reg.status;
    assign particle_reading = main_reg.reading;

    `PSFD_ASSERT_ALWAYS(a_skid_implies_main, clk, (!rst_n || !skid_valid_reg || main_valid_reg), "skid held, output empty")
    `PSFD_ASSERT(a_no_push_when_full, clk, rst_n, !(push && skid_valid_reg), "push into full skid slot")
    `PSFD_ASSERT(a_stall_push_to_skid, clk, rst_n, (main_valid_reg && out_stall && push) |=> skid_valid_reg, "stalled push lost")
    `PSFD_ASSERT(a_drain_empties, clk, rst_n, (out_fire && !skid_valid_reg && !push) |=> !main_valid_reg, "output not drained")

endmodule

// File: src/particle_sensor_frame_detector_core.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_detector_core
// Sliding-window frame detector for a serial particle sensor byte stream.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------
//  input    in_valid / in_stall    rx_byte[7:0]
//  output   out_valid / out_stall  frame_status[1:0], particle_reading[15:0]
//  config   APB psel/penable       paddr[3:0], pwdata/prdata[31:0]
//
//  One byte is accepted per cycle while in_stall is low; its result goes to
//  the result register, or to the skid slot while the output is stalled. The
//  running sum and header compare sit between the window and result registers.
//  Reset clears the window and sum, and loads the header registers with their
//  defaults. in_stall rises only while the one-result skid slot is occupied.
// ----------------------------------------------------------------------------
module particle_sensor_frame_detector_core
#(
    parameter int unsigned FRAME_BYTES = 20
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [psfd_pkg::BYTE_W-1:0]     rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      frame_status,
    output logic [psfd_pkg::READING_W-1:0]  particle_reading,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psfd_pkg::ADDR_W-1:0]     paddr,
    input  logic [psfd_pkg::DATA_W-1:0]     pwdata,
    output logic [psfd_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    psfd_pkg::header_cfg_t hdr;
    psfd_pkg::result_t     result;
    logic                  accept;
    logic                  full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Header registers
    psfd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hdr     (hdr)
    );

    // Window, running sum and classification
    psfd_window #(.FRAME_BYTES(FRAME_BYTES)) u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .hdr     (hdr),
        .result  (result)
    );

    // Result register and skid slot
    psfd_out_skid u_out_skid
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (accept),
        .result_in        (result),
        .full             (full),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .frame_status     (frame_status),
        .particle_reading (particle_reading)
    );

endmodule
